// ===== rtl/core/prg_pkg.sv =====
// Shared types and constants for the point range and elevation gate.
package prg_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned TAN_W      = 24;
  localparam int unsigned RANGE_W    = 23;
  localparam int unsigned TAN_SQ_W   = 2 * TAN_W;
  localparam int unsigned RANGE_SQ_W = 2 * RANGE_W;
  localparam int unsigned CHUNK_W    = 24;
  localparam int unsigned TAN_CHUNKS = TAN_SQ_W / CHUNK_W;
  // dz^2 * 2^32 lines up with tan^2 in Q16.32
  localparam int unsigned TAN_FRAC2  = 32;

  localparam logic [RANGE_W-1:0] MAX_RANGE_RST = RANGE_W'(35000);
  localparam logic [TAN_W-1:0]   MIN_TAN_RST   = TAN_W'(-37837);
  localparam logic [TAN_W-1:0]   MAX_TAN_RST   = TAN_W'(37837);

  typedef enum logic [2:0] {
    REG_SENSOR_X     = 3'd0,
    REG_SENSOR_Y     = 3'd1,
    REG_SENSOR_Z     = 3'd2,
    REG_MAX_RANGE    = 3'd3,
    REG_MIN_ELEV_TAN = 3'd4,
    REG_MAX_ELEV_TAN = 3'd5
  } cfg_reg_t;

  // limits derived from the config registers
  typedef struct packed {
    logic [TAN_SQ_W-1:0]   tan_min_sq;
    logic [TAN_SQ_W-1:0]   tan_max_sq;
    logic                  min_le0;
    logic                  max_ge0;
    logic [RANGE_SQ_W-1:0] range_sq;
  } lim_t;

  // control bits that travel with a point word
  typedef struct packed {
    logic valid;
    logic dz_pos;
    logic dz_neg;
  } tag_t;

endpackage

// ===== rtl/core/prg_cfg.sv =====
// APB register file and the squared limits derived from it.
module prg_cfg #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [prg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [prg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [prg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [COORD_BITS-1:0]             sensor_x,
  output logic [COORD_BITS-1:0]             sensor_y,
  output logic [COORD_BITS-1:0]             sensor_z,
  output prg_pkg::lim_t                     lim
);

  logic [prg_pkg::RANGE_W-1:0] max_range;
  logic [prg_pkg::TAN_W-1:0]   min_tan;
  logic [prg_pkg::TAN_W-1:0]   max_tan;
  logic                        wr_en;
  prg_pkg::cfg_reg_t           reg_sel;

  logic signed [prg_pkg::TAN_SQ_W-1:0] min_sq;
  logic signed [prg_pkg::TAN_SQ_W-1:0] max_sq;
  logic [prg_pkg::RANGE_SQ_W-1:0]      range_sq;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = prg_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_x  <= '0;
      sensor_y  <= '0;
      sensor_z  <= '0;
      max_range <= prg_pkg::MAX_RANGE_RST;
      min_tan   <= prg_pkg::MIN_TAN_RST;
      max_tan   <= prg_pkg::MAX_TAN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        prg_pkg::REG_SENSOR_X:     sensor_x  <= pwdata[COORD_BITS-1:0];
        prg_pkg::REG_SENSOR_Y:     sensor_y  <= pwdata[COORD_BITS-1:0];
        prg_pkg::REG_SENSOR_Z:     sensor_z  <= pwdata[COORD_BITS-1:0];
        prg_pkg::REG_MAX_RANGE:    max_range <= pwdata[prg_pkg::RANGE_W-1:0];
        prg_pkg::REG_MIN_ELEV_TAN: min_tan   <= pwdata[prg_pkg::TAN_W-1:0];
        prg_pkg::REG_MAX_ELEV_TAN: max_tan   <= pwdata[prg_pkg::TAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      prg_pkg::REG_SENSOR_X:     prdata = prg_pkg::APB_DATA_W'($signed(sensor_x));
      prg_pkg::REG_SENSOR_Y:     prdata = prg_pkg::APB_DATA_W'($signed(sensor_y));
      prg_pkg::REG_SENSOR_Z:     prdata = prg_pkg::APB_DATA_W'($signed(sensor_z));
      prg_pkg::REG_MAX_RANGE:    prdata = prg_pkg::APB_DATA_W'(max_range);
      prg_pkg::REG_MIN_ELEV_TAN: prdata = prg_pkg::APB_DATA_W'($signed(min_tan));
      prg_pkg::REG_MAX_ELEV_TAN: prdata = prg_pkg::APB_DATA_W'($signed(max_tan));
      default:                   prdata = '0;
    endcase
  end

  assign min_sq   = $signed(min_tan) * $signed(min_tan);
  assign max_sq   = $signed(max_tan) * $signed(max_tan);
  assign range_sq = prg_pkg::RANGE_SQ_W'(max_range) * prg_pkg::RANGE_SQ_W'(max_range);

  // registered every cycle; config must only move while the pipe is empty, which the block does not enforce
  always_ff @(posedge clk) begin
    lim.tan_min_sq <= min_sq;
    lim.tan_max_sq <= max_sq;
    lim.min_le0    <= min_tan[prg_pkg::TAN_W-1] | (min_tan == '0);
    lim.max_ge0    <= ~max_tan[prg_pkg::TAN_W-1];
    lim.range_sq   <= range_sq;
  end

endmodule

// ===== rtl/core/prg_geom.sv =====
// Front stages: offsets from the sensor, their squares and the distance sums.
module prg_geom #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [COORD_BITS-1:0]     px,
  input  logic [COORD_BITS-1:0]     py,
  input  logic [COORD_BITS-1:0]     pz,
  input  logic [COORD_BITS-1:0]     sensor_x,
  input  logic [COORD_BITS-1:0]     sensor_y,
  input  logic [COORD_BITS-1:0]     sensor_z,
  output prg_pkg::tag_t             tag,
  output logic [COORD_BITS-1:0]     qx,
  output logic [COORD_BITS-1:0]     qy,
  output logic [COORD_BITS-1:0]     qz,
  output logic [2*COORD_BITS:0]     hsq,
  output logic [2*COORD_BITS+1:0]   dsq,
  output logic [2*COORD_BITS-1:0]   zsq
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned SQ_W = 2 * C;
  localparam int unsigned H_W  = SQ_W + 1;
  localparam int unsigned D_W  = SQ_W + 2;

  logic signed [C:0] dx, dy, dz;
  logic signed [C:0] nx, ny, nz;

  // stage 0: absolute offsets
  prg_pkg::tag_t   tag0;
  logic [C-1:0]    ux, uy, uz;
  logic [C-1:0]    x0, y0, z0;
  // stage 1: squares
  prg_pkg::tag_t   tag1;
  logic [SQ_W-1:0] sqx, sqy, sqz;
  logic [C-1:0]    x1, y1, z1;

  assign dx = $signed({px[C-1], px}) - $signed({sensor_x[C-1], sensor_x});
  assign dy = $signed({py[C-1], py}) - $signed({sensor_y[C-1], sensor_y});
  assign dz = $signed({pz[C-1], pz}) - $signed({sensor_z[C-1], sensor_z});
  assign nx = -dx;
  assign ny = -dy;
  assign nz = -dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0.valid <= 1'b0;
      tag1.valid <= 1'b0;
      tag.valid  <= 1'b0;
    end else begin
      tag0.valid <= in_valid;
      tag1.valid <= tag0.valid;
      tag.valid  <= tag1.valid;
    end

    // magnitude of a difference of two C-bit values fits in C bits
    ux          <= dx[C] ? nx[C-1:0] : dx[C-1:0];
    uy          <= dy[C] ? ny[C-1:0] : dy[C-1:0];
    uz          <= dz[C] ? nz[C-1:0] : dz[C-1:0];
    tag0.dz_neg <= dz[C];
    tag0.dz_pos <= ~dz[C] & (dz != '0);
    x0          <= px;
    y0          <= py;
    z0          <= pz;

    sqx         <= SQ_W'(ux) * SQ_W'(ux);
    sqy         <= SQ_W'(uy) * SQ_W'(uy);
    sqz         <= SQ_W'(uz) * SQ_W'(uz);
    tag1.dz_neg <= tag0.dz_neg;
    tag1.dz_pos <= tag0.dz_pos;
    x1          <= x0;
    y1          <= y0;
    z1          <= z0;

    hsq         <= H_W'(sqx) + H_W'(sqy);
    dsq         <= D_W'(sqx) + D_W'(sqy) + D_W'(sqz);
    zsq         <= sqz;
    tag.dz_neg  <= tag1.dz_neg;
    tag.dz_pos  <= tag1.dz_pos;
    qx          <= x1;
    qy          <= y1;
    qz          <= z1;
  end

endmodule

// ===== rtl/core/prg_elev.sv =====
// Back stages: range test, tan^2 * H in partial products, elevation decision.
module prg_elev #(
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned MIN_RANGE_MM = 200
) (
  input  logic                      clk,
  input  logic                      rst,
  input  prg_pkg::tag_t             tag,
  input  logic [COORD_BITS-1:0]     qx,
  input  logic [COORD_BITS-1:0]     qy,
  input  logic [COORD_BITS-1:0]     qz,
  input  logic [2*COORD_BITS:0]     hsq,
  input  logic [2*COORD_BITS+1:0]   dsq,
  input  logic [2*COORD_BITS-1:0]   zsq,
  input  prg_pkg::lim_t             lim,
  output logic                      done,
  output logic [COORD_BITS-1:0]     kept_x,
  output logic [COORD_BITS-1:0]     kept_y,
  output logic [COORD_BITS-1:0]     kept_z
);

  localparam int unsigned C      = COORD_BITS;
  localparam int unsigned SQ_W   = 2 * C;
  localparam int unsigned H_W    = SQ_W + 1;
  localparam int unsigned D_W    = SQ_W + 2;
  localparam int unsigned CW     = prg_pkg::CHUNK_W;
  localparam int unsigned TCH    = prg_pkg::TAN_CHUNKS;
  localparam int unsigned HCH    = (H_W + CW - 1) / CW;
  localparam int unsigned HP_W   = HCH * CW;
  localparam int unsigned PP_W   = 2 * CW;
  localparam int unsigned R_W    = HP_W + prg_pkg::TAN_SQ_W;
  localparam int unsigned A_W    = SQ_W + prg_pkg::TAN_FRAC2;
  localparam int unsigned CMP_W  = (R_W > A_W) ? R_W : A_W;
  localparam logic [D_W-1:0] RMIN_SQ = D_W'(MIN_RANGE_MM * MIN_RANGE_MM);

  logic [HP_W-1:0] h_pad;

  // stage 3: partial products and range test
  prg_pkg::tag_t   tag3;
  logic            range_ok3, h_zero3;
  logic [SQ_W-1:0] zsq3;
  logic [PP_W-1:0] pp_min [HCH][TCH];
  logic [PP_W-1:0] pp_max [HCH][TCH];
  logic [C-1:0]    x3, y3, z3;

  // stage 4: summed products
  prg_pkg::tag_t   tag4;
  logic            range_ok4, h_zero4;
  logic [SQ_W-1:0] zsq4;
  logic [R_W-1:0]  r_min, r_max;
  logic [R_W-1:0]  sum_min, sum_max;
  logic [C-1:0]    x4, y4, z4;

  logic [CMP_W-1:0] a2, rmin_c, rmax_c;
  logic             ge_min, le_min, ge_max, le_max;
  logic             on_sensor, lower_ok, upper_ok, keep;

  assign h_pad = HP_W'(hsq);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag4.valid & keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag3.valid <= 1'b0;
    end else begin
      tag3.valid <= tag.valid;
    end
    for (int i = 0; i < HCH; i++) begin
      for (int j = 0; j < TCH; j++) begin
        pp_min[i][j] <= PP_W'(h_pad[i*CW +: CW]) * PP_W'(lim.tan_min_sq[j*CW +: CW]);
        pp_max[i][j] <= PP_W'(h_pad[i*CW +: CW]) * PP_W'(lim.tan_max_sq[j*CW +: CW]);
      end
    end
    range_ok3   <= (dsq >= RMIN_SQ) & (dsq <= D_W'(lim.range_sq));
    h_zero3     <= (hsq == '0);
    zsq3        <= zsq;
    tag3.dz_pos <= tag.dz_pos;
    tag3.dz_neg <= tag.dz_neg;
    x3          <= qx;
    y3          <= qy;
    z3          <= qz;
  end

  always_comb begin
    sum_min = '0;
    sum_max = '0;
    for (int i = 0; i < HCH; i++) begin
      for (int j = 0; j < TCH; j++) begin
        sum_min = sum_min + (R_W'(pp_min[i][j]) << (CW * (i + j)));
        sum_max = sum_max + (R_W'(pp_max[i][j]) << (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag4.valid <= 1'b0;
    end else begin
      tag4.valid <= tag3.valid;
    end
    r_min       <= sum_min;
    r_max       <= sum_max;
    range_ok4   <= range_ok3;
    h_zero4     <= h_zero3;
    zsq4        <= zsq3;
    tag4.dz_pos <= tag3.dz_pos;
    tag4.dz_neg <= tag3.dz_neg;
    x4          <= x3;
    y4          <= y3;
    z4          <= z3;
  end

  // stage 5: compare (dz * 2^16)^2 against tan^2 * H, per sign of dz
  assign a2     = CMP_W'({zsq4, {prg_pkg::TAN_FRAC2{1'b0}}});
  assign rmin_c = CMP_W'(r_min);
  assign rmax_c = CMP_W'(r_max);
  assign ge_min = a2 >= rmin_c;
  assign le_min = a2 <= rmin_c;
  assign ge_max = a2 >= rmax_c;
  assign le_max = a2 <= rmax_c;

  // point exactly at the sensor has elevation zero
  assign on_sensor = h_zero4 & ~tag4.dz_pos & ~tag4.dz_neg;

  always_comb begin
    priority if (on_sensor)                    lower_ok = lim.min_le0;
    else if (~tag4.dz_neg & lim.min_le0)       lower_ok = 1'b1;
    else if (tag4.dz_neg & ~lim.min_le0)       lower_ok = 1'b0;
    else if (~tag4.dz_neg)                     lower_ok = ge_min;
    else                                       lower_ok = le_min;

    priority if (on_sensor)                    upper_ok = lim.max_ge0;
    else if (~tag4.dz_pos & lim.max_ge0)       upper_ok = 1'b1;
    else if (tag4.dz_pos & ~lim.max_ge0)       upper_ok = 1'b0;
    else if (tag4.dz_pos)                      upper_ok = le_max;
    else                                       upper_ok = ge_max;
  end

  assign keep = range_ok4 & lower_ok & upper_ok;

  always_ff @(posedge clk) begin
    kept_x <= x4;
    kept_y <= y4;
    kept_z <= z4;
  end

endmodule

// ===== rtl/core/point_range_elevation_gate_top.sv =====
// Top level of the lidar point range and elevation gate.
//
// Point channel: drive point_x/y/z and raise start for one cycle; the word is
// taken at a rising edge with start high and busy low. busy is low except
// during reset, so a new point can be taken every cycle.
// Result channel: a kept point shows on kept_x/y/z with done high for exactly
// one cycle, once it has passed the register stages listed below.
// Dropped points give no word.
// Words leave in the order they came in; the receiver cannot stall, so there
// is no back pressure anywhere in the pipe.
// Throughput is one point per cycle. The pipe has six register stages:
// offsets, squares, distance sums, range test with partial products of
// tan^2 * H, product sums, elevation compare.
// Config: APB registers at byte offsets 0x00 to 0x14 (sensor x, y, z, maximum
// range, lower and upper elevation tangent in Q7.16). Write only while no
// point is in flight.
// Reset (rst, synchronous) empties the pipe and loads the register defaults.
module point_range_elevation_gate_top #(
  parameter int unsigned COORD_BITS   = 24,
  parameter int unsigned MIN_RANGE_MM = 200
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [COORD_BITS-1:0]           point_x,
  input  logic [COORD_BITS-1:0]           point_y,
  input  logic [COORD_BITS-1:0]           point_z,
  output logic                            done,
  output logic [COORD_BITS-1:0]           kept_x,
  output logic [COORD_BITS-1:0]           kept_y,
  output logic [COORD_BITS-1:0]           kept_z,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [prg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [prg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  logic                    in_valid;
  logic [COORD_BITS-1:0]   sensor_x, sensor_y, sensor_z;
  prg_pkg::lim_t           lim;
  prg_pkg::tag_t           tag;
  logic [COORD_BITS-1:0]   qx, qy, qz;
  logic [2*COORD_BITS:0]   hsq;
  logic [2*COORD_BITS+1:0] dsq;
  logic [2*COORD_BITS-1:0] zsq;

  assign busy     = rst;
  assign in_valid = start & ~busy;

  prg_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sensor_x (sensor_x),
    .sensor_y (sensor_y),
    .sensor_z (sensor_z),
    .lim      (lim)
  );

  prg_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .px       (point_x),
    .py       (point_y),
    .pz       (point_z),
    .sensor_x (sensor_x),
    .sensor_y (sensor_y),
    .sensor_z (sensor_z),
    .tag      (tag),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .hsq      (hsq),
    .dsq      (dsq),
    .zsq      (zsq)
  );

  prg_elev #(
    .COORD_BITS   (COORD_BITS),
    .MIN_RANGE_MM (MIN_RANGE_MM)
  ) u_elev (
    .clk    (clk),
    .rst    (rst),
    .tag    (tag),
    .qx     (qx),
    .qy     (qy),
    .qz     (qz),
    .hsq    (hsq),
    .dsq    (dsq),
    .zsq    (zsq),
    .lim    (lim),
    .done   (done),
    .kept_x (kept_x),
    .kept_y (kept_y),
    .kept_z (kept_z)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the point range and elevation gate.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = 24;
  localparam int MIN_RANGE_MM = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;
  localparam int RAND_PHASES  = 5;
  localparam int RAND_PER_PHASE = 80;
  // byte offsets past the last register
  localparam logic [prg_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR_A = 5'h18;
  localparam logic [prg_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR_B = 5'h1C;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [CW-1:0] point_x, point_y, point_z;
  logic done;
  logic [CW-1:0] kept_x, kept_y, kept_z;
  logic psel, penable, pwrite;
  logic [prg_pkg::CFG_ADDR_W-1:0] paddr;
  logic [prg_pkg::APB_DATA_W-1:0] pwdata, prdata;
  logic pready;

  // local copy of the view registers
  logic signed [CW-1:0]             view_sx, view_sy, view_sz;
  logic [prg_pkg::RANGE_W-1:0]      view_range;
  logic signed [prg_pkg::TAN_W-1:0] view_tan_lo, view_tan_hi;

  point_t kept_q[$];
  int errors = 0;
  int n_points = 0;
  int n_kept = 0;
  int n_cfg = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;

  point_range_elevation_gate_top #(
    .COORD_BITS  (CW),
    .MIN_RANGE_MM(MIN_RANGE_MM)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .done   (done),
    .kept_x (kept_x),
    .kept_y (kept_y),
    .kept_z (kept_z),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic note_fail(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endtask

  // appends a predicted word at the tail of the expected queue
  function automatic void queue_kept(input point_t p);
    kept_q.insert(kept_q.size(), p);
  endfunction

  // Exact range shell and elevation test, all squares kept in 128 bits.
  function automatic bit point_in_view(input logic [CW-1:0] px, py, pz);
    longint dx, dy, dz, tlo, thi;
    logic [127:0] hsq, zsq, dsq, zsq_q32, bound;
    bit lo_ok, hi_ok;
    dx = longint'($signed(px)) - longint'(view_sx);
    dy = longint'($signed(py)) - longint'(view_sy);
    dz = longint'($signed(pz)) - longint'(view_sz);
    hsq = 128'(dx * dx + dy * dy);
    zsq = 128'(dz * dz);
    dsq = hsq + zsq;
    if (dsq < 128'(MIN_RANGE_MM * MIN_RANGE_MM) ||
        dsq > 128'(view_range) * 128'(view_range))
      return 1'b0;
    tlo = longint'(view_tan_lo);
    thi = longint'(view_tan_hi);
    if (dz == 0 && hsq == 0) begin
      lo_ok = (tlo <= 0);
      hi_ok = (thi >= 0);
    end else begin
      // dz in Q.16 squared lines up with tan^2 * H
      zsq_q32 = zsq << 32;
      if (dz >= 0 && tlo <= 0) begin
        lo_ok = 1'b1;
      end else if (dz < 0 && tlo > 0) begin
        lo_ok = 1'b0;
      end else begin
        bound = hsq * 128'(tlo * tlo);
        lo_ok = (dz >= 0) ? (zsq_q32 >= bound) : (zsq_q32 <= bound);
      end
      if (dz <= 0 && thi >= 0) begin
        hi_ok = 1'b1;
      end else if (dz > 0 && thi < 0) begin
        hi_ok = 1'b0;
      end else begin
        bound = hsq * 128'(thi * thi);
        hi_ok = (dz > 0) ? (zsq_q32 <= bound) : (zsq_q32 >= bound);
      end
    end
    return lo_ok && hi_ok;
  endfunction

  task automatic apb_xfer(input bit wr, input logic [prg_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [prg_pkg::APB_DATA_W-1:0] wdata,
                          output logic [prg_pkg::APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(input prg_pkg::cfg_reg_t r,
                           input logic [prg_pkg::APB_DATA_W-1:0] v);
    logic [prg_pkg::APB_DATA_W-1:0] unused;
    apb_xfer(1'b1, {r, 2'b00}, v, unused);
    n_cfg++;
    case (r)
      prg_pkg::REG_SENSOR_X:     view_sx     = v[CW-1:0];
      prg_pkg::REG_SENSOR_Y:     view_sy     = v[CW-1:0];
      prg_pkg::REG_SENSOR_Z:     view_sz     = v[CW-1:0];
      prg_pkg::REG_MAX_RANGE:    view_range  = v[prg_pkg::RANGE_W-1:0];
      prg_pkg::REG_MIN_ELEV_TAN: view_tan_lo = v[prg_pkg::TAN_W-1:0];
      prg_pkg::REG_MAX_ELEV_TAN: view_tan_hi = v[prg_pkg::TAN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_readback(input prg_pkg::cfg_reg_t r);
    logic [prg_pkg::APB_DATA_W-1:0] rd;
    logic [prg_pkg::APB_DATA_W-1:0] want;
    bit ok;
    apb_xfer(1'b0, {r, 2'b00}, '0, rd);
    case (r)
      prg_pkg::REG_SENSOR_X: begin
        want = 32'(view_sx);
        ok   = rd[CW-1:0] == view_sx;
      end
      prg_pkg::REG_SENSOR_Y: begin
        want = 32'(view_sy);
        ok   = rd[CW-1:0] == view_sy;
      end
      prg_pkg::REG_SENSOR_Z: begin
        want = 32'(view_sz);
        ok   = rd[CW-1:0] == view_sz;
      end
      prg_pkg::REG_MAX_RANGE: begin
        want = 32'(view_range);
        ok   = rd[prg_pkg::RANGE_W-1:0] == view_range;
      end
      prg_pkg::REG_MIN_ELEV_TAN: begin
        want = 32'(view_tan_lo);
        ok   = rd[prg_pkg::TAN_W-1:0] == view_tan_lo;
      end
      default: begin
        want = 32'(view_tan_hi);
        ok   = rd[prg_pkg::TAN_W-1:0] == view_tan_hi;
      end
    endcase
    if (!ok) note_fail($sformatf("readback %s: expected %h got %h", r.name(), want, rd));
  endtask

  task automatic readback_all();
    cfg_readback(prg_pkg::REG_SENSOR_X);
    cfg_readback(prg_pkg::REG_SENSOR_Y);
    cfg_readback(prg_pkg::REG_SENSOR_Z);
    cfg_readback(prg_pkg::REG_MAX_RANGE);
    cfg_readback(prg_pkg::REG_MIN_ELEV_TAN);
    cfg_readback(prg_pkg::REG_MAX_ELEV_TAN);
  endtask

  // Holds start high until the word is taken, then predicts the kept point.
  task automatic send_point(input logic [CW-1:0] x, y, z);
    point_t p;
    p = '{x: x, y: y, z: z};
    if (idle_on && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_points++;
    if (point_in_view(x, y, z)) queue_kept(p);
  endtask

  // Lets the pipe empty, dropped points included, before touching registers.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    readback_all();
    send_point(24'(1000), 24'(0), 24'(0));
    send_point(24'(0), 24'(0), 24'(1000));     // straight up
    send_point(24'(0), 24'(0), -24'(1000));    // straight down
    send_point(24'(0), 24'(0), 24'(0));        // at the sensor
    send_point(24'(199), 24'(0), 24'(0));
    send_point(24'(200), 24'(0), 24'(0));      // inner shell edge
    send_point(24'(0), -24'(200), 24'(0));
    send_point(24'(35000), 24'(0), 24'(0));    // outer shell edge
    send_point(24'(35001), 24'(0), 24'(0));
    send_point(24'(10000), 24'(0), 24'(6000));
    drain();
  endtask

  task automatic test_elevation_edges();
    cfg_write(prg_pkg::REG_MAX_RANGE, 32'(8388607));
    // H = 2^32 makes tan * sqrt(H) an integer: exact boundary hits
    send_point(24'(65536), 24'(0), 24'(37837));
    send_point(24'(65536), 24'(0), 24'(37838));
    send_point(24'(0), 24'(65536), -24'(37837));
    send_point(-24'(65536), 24'(0), -24'(37838));
    drain();
    // upward-only view: level points fail the lower limit
    cfg_write(prg_pkg::REG_MIN_ELEV_TAN, 32'(1));
    cfg_write(prg_pkg::REG_MAX_ELEV_TAN, 32'(8388607));
    send_point(24'(5000), 24'(0), 24'(0));
    send_point(24'(5000), 24'(0), 24'(1));
    send_point(24'(0), 24'(0), 24'(5000));
    drain();
  endtask

  task automatic test_extremes();
    cfg_write(prg_pkg::REG_SENSOR_X, 32'(8388607));
    cfg_write(prg_pkg::REG_SENSOR_Y, 32'(-8388608));
    cfg_write(prg_pkg::REG_SENSOR_Z, 32'(8388607));
    cfg_write(prg_pkg::REG_MIN_ELEV_TAN, 32'(-8388608));
    cfg_write(prg_pkg::REG_MAX_ELEV_TAN, 32'(8388607));
    readback_all();
    send_point(24'h800000, 24'h7fffff, 24'h800000);
    send_point(24'h7fffff, 24'h800000, 24'(8388407));
    send_point(24'h7fffff, 24'h800000, 24'h7fffff);
    send_point(24'(8387607), 24'h800000, 24'h800000);
    drain();
    // crossed limits: nothing passes the elevation test
    cfg_write(prg_pkg::REG_MIN_ELEV_TAN, 32'(65536));
    cfg_write(prg_pkg::REG_MAX_ELEV_TAN, 32'(-65536));
    send_point(24'(8387607), 24'h800000, 24'h7fffff);
    send_point(24'h7fffff, 24'(-8387608), 24'(8387607));
    drain();
    cfg_write(prg_pkg::REG_MAX_RANGE, 32'(0));
    cfg_write(prg_pkg::REG_MIN_ELEV_TAN, 32'(-65536));
    cfg_write(prg_pkg::REG_MAX_ELEV_TAN, 32'(65536));
    send_point(24'h7fffff, 24'(-8388308), 24'h7fffff);
    drain();
  endtask

  task automatic test_unmapped_write();
    logic [prg_pkg::APB_DATA_W-1:0] unused;
    cfg_write(prg_pkg::REG_MAX_RANGE, 32'(20000));
    apb_xfer(1'b1, UNMAPPED_ADDR_A, 32'hffffffff, unused);
    apb_xfer(1'b1, UNMAPPED_ADDR_B, 32'h00a5a5a5, unused);
    readback_all();
    send_point(24'h7fffff, 24'(-8378608), 24'h7fffff);
    drain();
  endtask

  task automatic random_view();
    cfg_write(prg_pkg::REG_SENSOR_X, ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(int'($urandom_range(0, 40000)) - 20000));
    cfg_write(prg_pkg::REG_SENSOR_Y, ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(int'($urandom_range(0, 40000)) - 20000));
    cfg_write(prg_pkg::REG_SENSOR_Z, ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(int'($urandom_range(0, 4000)) - 2000));
    case ($urandom_range(0, 9))
      0:       cfg_write(prg_pkg::REG_MAX_RANGE, 32'(8388607));
      1:       cfg_write(prg_pkg::REG_MAX_RANGE, $urandom);
      default: cfg_write(prg_pkg::REG_MAX_RANGE, 32'($urandom_range(500, 60000)));
    endcase
    cfg_write(prg_pkg::REG_MIN_ELEV_TAN, ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(-int'($urandom_range(0, 131072))));
    cfg_write(prg_pkg::REG_MAX_ELEV_TAN, ($urandom_range(0, 9) == 0) ? $urandom
              : 32'(int'($urandom_range(0, 131072)) - 16384));
  endtask

  task automatic random_point();
    int mode, span, h, adj;
    longint t, dzl;
    logic [CW-1:0] x, y, z;
    mode = $urandom_range(0, 99);
    span = int'(view_range) / 2 + 1;
    x = view_sx;
    y = view_sy;
    z = view_sz;
    if (mode < 65) begin
      // within half the maximum range of the sensor on each axis
      x = 24'(int'(view_sx) + int'($urandom_range(0, 2 * span)) - span);
      y = 24'(int'(view_sy) + int'($urandom_range(0, 2 * span)) - span);
      z = 24'(int'(view_sz) + int'($urandom_range(0, 2 * span)) - span);
    end else if (mode < 80) begin
      // within one step of an elevation limit
      t = $urandom_range(0, 1) ? longint'(view_tan_lo) : longint'(view_tan_hi);
      h = $urandom_range(1, 30000);
      adj = int'($urandom_range(0, 2)) - 1;
      dzl = ((longint'(h) * t) >>> 16) + longint'(adj);
      if ($urandom_range(0, 1)) h = -h;
      if ($urandom_range(0, 1)) x = 24'(int'(view_sx) + h);
      else y = 24'(int'(view_sy) + h);
      z = 24'(longint'(view_sz) + dzl);
    end else if (mode < 95) begin
      x = 24'($urandom);
      y = 24'($urandom);
      z = 24'($urandom);
    end else begin
      // near the sensor: inner shell and vertical axis
      if ($urandom_range(0, 1)) begin
        x = 24'(int'(view_sx) + int'($urandom_range(0, 600)) - 300);
        y = 24'(int'(view_sy) + int'($urandom_range(0, 600)) - 300);
      end
      z = 24'(int'(view_sz) + int'($urandom_range(0, 600)) - 300);
    end
    send_point(x, y, z);
  endtask

  task automatic test_random_stream();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_view();
      idle_on = (ph != 1);
      for (int i = 0; i < RAND_PER_PHASE; i++) random_point();
      drain();
    end
    idle_on = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    point_t want;
    if (!rst && done) begin
      if (kept_q.size() == 0) begin
        note_fail($sformatf("unexpected word %h %h %h", kept_x, kept_y, kept_z));
      end else begin
        want = kept_q.pop_front();
        n_kept++;
        if (kept_x !== want.x) note_fail($sformatf("kept_x: expected %h got %h", want.x, kept_x));
        if (kept_y !== want.y) note_fail($sformatf("kept_y: expected %h got %h", want.y, kept_y));
        if (kept_z !== want.z) note_fail($sformatf("kept_z: expected %h got %h", want.z, kept_z));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst     = 1'b1;
    start   = 1'b0;
    point_x = '0;
    point_y = '0;
    point_z = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    view_sx     = '0;
    view_sy     = '0;
    view_sz     = '0;
    view_range  = prg_pkg::MAX_RANGE_RST;
    view_tan_lo = prg_pkg::MIN_TAN_RST;
    view_tan_hi = prg_pkg::MAX_TAN_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_elevation_edges();
    test_extremes();
    test_unmapped_write();
    test_random_stream();

    drain();
    if (kept_q.size() != 0) note_fail($sformatf("%0d kept points never came", kept_q.size()));
    $display("Sent %0d points, %0d came through the gate, %0d dropped; %0d register writes",
             n_points, n_kept, n_points - n_kept, n_cfg);
    $display("Errors: %0d", errors);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
